// ----- design/pwcs_pkg.sv -----
package pwcs_pkg;

  localparam int TS_W     = 64;
  localparam int US_W     = 63;
  localparam int MIN_W    = 11;
  localparam int PERIOD_W = 37;

  localparam logic [25:0]        US_PER_MINUTE = 26'd60000000;
  localparam logic signed [63:0] TOLERANCE_US  = 64'sd2000000;
  localparam logic signed [63:0] IMMEDIATE_US  = 64'sd1000000;
  localparam logic signed [63:0] SMAX          = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SMIN          = 64'sh8000_0000_0000_0000;

  typedef enum logic [1:0] {
    KIND_WAKE   = 2'd0,
    KIND_SLEEP  = 2'd1,
    KIND_FORCE  = 2'd2,
    KIND_MOTION = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                   kind;
    logic [TS_W-1:0]         clock_us;
    logic                    woke_from_sleep;
    logic                    server_due;
    logic                    server_active;
    logic signed [TS_W-1:0]  srv_left_us;
  } item_t;

  // packed so that has_report_work sits in bit 0
  typedef struct packed {
    logic            clear_server_due;
    logic [US_W-1:0] sleep_us;
    logic [US_W-1:0] elapsed_us;
    logic            run_motion;
    logic            run_periodic;
    logic            has_report_work;
  } result_t;

endpackage

// ----- design/pwcs_front.sv -----
module pwcs_front
  import pwcs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,
  input  logic [1:0]   in_tuser,
  output logic         f_valid,
  output item_t        f_item,
  input  logic         f_ready
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  in_fire;

  assign in_tready = !valid_r || f_ready;
  assign in_fire   = in_tvalid && in_tready;
  assign valid_nxt = in_fire || (valid_r && !f_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.kind            <= kind_t'(in_tuser);
      item_r.clock_us        <= in_tdata[63:0];
      item_r.woke_from_sleep <= in_tdata[64];
      item_r.server_due      <= in_tdata[65];
      item_r.server_active   <= in_tdata[66];
      item_r.srv_left_us     <= $signed(in_tdata[130:67]);
    end
  end

  assign f_valid = valid_r;
  assign f_item  = item_r;

endmodule

// ----- design/pwcs_queue.sv -----
module pwcs_queue
  import pwcs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  not_full,
  input  logic  pop,
  output logic  q_valid,
  output item_t q_item
);

  item_t      slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign not_full = (count_r != 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- design/pwcs_back.sv -----
module pwcs_back
  import pwcs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [MIN_W-1:0] cfg_wr_data,
  input  logic             q_valid,
  input  item_t            q_item,
  output logic             q_pop,
  output logic             res_valid,
  input  logic             res_ready,
  output result_t          res
);

  logic [PERIOD_W-1:0]    period_r;
  logic signed [63:0]     cd_r, cd_nxt;
  logic [TS_W-1:0]        last_r, last_nxt;
  logic [TS_W-1:0]        cs_r, cs_nxt;
  logic                   pr_r, pr_nxt;
  logic                   mot_r, mot_nxt;
  logic                   valid_r;
  result_t                res_r, res_nxt;

  logic                   en;
  logic signed [63:0]     period_s;
  logic                   cold;
  logic [US_W-1:0]        slept, work;
  logic signed [63:0]     cd_w, cd_s2, cd_s3, nxt;
  logic                   pr_w;
  logic [TS_W-1:0]        now;

  function automatic logic [US_W-1:0] diff_sat(input logic [TS_W-1:0] later,
                                                input logic [TS_W-1:0] earlier);
    logic [TS_W-1:0] d;
    d = later - earlier;
    return d[63] ? {US_W{1'b1}} : d[US_W-1:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic [US_W-1:0] b);
    logic [64:0] d;
    d = {a[63], a} - {2'b00, b};
    return (d[64:63] == 2'b10) ? SMIN : $signed(d[63:0]);
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic [PERIOD_W-1:0] b);
    logic [64:0] d;
    d = {a[63], a} + {{(65 - PERIOD_W){1'b0}}, b};
    return (d[64:63] == 2'b01) ? SMAX : $signed(d[63:0]);
  endfunction

  assign q_pop    = q_valid && (!valid_r || res_ready);
  assign en       = (period_r != '0);
  assign period_s = $signed({{(64 - PERIOD_W){1'b0}}, period_r});
  assign now      = q_item.clock_us;

  // wake evaluation
  always_comb begin
    cold  = !q_item.woke_from_sleep || (last_r == '0) || (now < last_r);
    slept = cold ? '0 : diff_sat(now, last_r);
    cd_w  = cold ? 64'sd0 : sat_sub(cd_r, slept);
    if (!en) begin
      cd_w = SMAX;
    end
    pr_w = en && (cd_w <= TOLERANCE_US);
  end

  // sleep computation
  always_comb begin
    work  = ((cs_r != '0) && (now >= cs_r)) ? diff_sat(now, cs_r) : '0;
    cd_s2 = sat_sub(cd_r, work);
    cd_s3 = (en && pr_r) ? sat_add(cd_s2, period_r) : cd_s2;
    if (en && !pr_r && ((cd_s3 <= 64'sd0) || (cd_s3 > period_s))) begin
      cd_s3 = period_s;
    end
    nxt = en ? cd_s3 : -64'sd1;
    if (q_item.server_active) begin
      if (q_item.srv_left_us <= 64'sd0) begin
        nxt = IMMEDIATE_US;
      end else if ((nxt < 64'sd0) || (q_item.srv_left_us < nxt)) begin
        nxt = q_item.srv_left_us;
      end
    end
  end

  always_comb begin
    cd_nxt   = cd_r;
    last_nxt = last_r;
    cs_nxt   = cs_r;
    pr_nxt   = pr_r;
    mot_nxt  = mot_r;
    res_nxt  = '0;
    case (q_item.kind)
      KIND_WAKE: begin
        cs_nxt   = now;
        last_nxt = cold ? now : last_r;
        cd_nxt   = cd_w;
        pr_nxt   = pr_w;
        mot_nxt  = 1'b0;
        res_nxt.has_report_work = mot_r || pr_w || q_item.server_due;
        res_nxt.run_periodic    = pr_w;
        res_nxt.run_motion      = mot_r;
        res_nxt.elapsed_us      = slept;
      end
      KIND_SLEEP: begin
        last_nxt           = now;
        res_nxt.elapsed_us = work;
        if (!pr_r && en && (cd_s2 <= 64'sd0)) begin
          cd_nxt                   = cd_s2;
          res_nxt.sleep_us         = IMMEDIATE_US[US_W-1:0];
          res_nxt.clear_server_due = 1'b1;
        end else if (nxt < 64'sd0) begin
          cd_nxt = cd_s3;
        end else if (nxt == 64'sd0) begin
          cd_nxt           = en ? period_s : cd_s3;
          res_nxt.sleep_us = en ? period_s[US_W-1:0] : IMMEDIATE_US[US_W-1:0];
        end else begin
          cd_nxt           = cd_s3;
          res_nxt.sleep_us = (en && (nxt > period_s)) ? period_s[US_W-1:0]
                                                      : nxt[US_W-1:0];
        end
      end
      KIND_FORCE: begin
        cd_nxt = 64'sd0;
      end
      KIND_MOTION: begin
        mot_nxt = 1'b1;
      end
      default: begin
        cd_nxt = cd_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= '0;
      cd_r     <= '0;
      last_r   <= '0;
      cs_r     <= '0;
      pr_r     <= 1'b0;
      mot_r    <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        period_r <= PERIOD_W'(cfg_wr_data) * PERIOD_W'(US_PER_MINUTE);
      end
      if (q_pop) begin
        cd_r   <= cd_nxt;
        last_r <= last_nxt;
        cs_r   <= cs_nxt;
        pr_r   <= pr_nxt;
        mot_r  <= mot_nxt;
      end
      valid_r <= q_pop || (valid_r && !res_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = valid_r;
  assign res       = res_r;

endmodule

// ----- design/periodic_wake_countdown_scheduler.sv -----
// Periodic wake countdown scheduler.
// Input stream: one request per event. in_tuser holds the kind (wake, sleep,
// force capture, motion); in_tdata carries the clock reading and server task
// status. Every request yields exactly one result on the output stream, in
// order; force-capture and motion requests return an all-zero result.
// Configuration: cfg_wr_en with cfg_wr_data writes the period in minutes;
// write only while no request is in flight.
// A request passes through the input register, the two-entry queue and the
// back-end result register, in that order, before out_tvalid rises.
// Throughput: one request per cycle while out_tready stays high; the whole
// countdown update of a request is computed combinationally in the back end.
// Reset (rst_n low, synchronous) empties the pipeline, zeroes the period and
// all countdown state.
// When the receiver stalls, the result register holds, the queue fills and
// in_tready drops once the input register and both queue entries are full;
// nothing is lost or repeated.
module periodic_wake_countdown_scheduler
  import pwcs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [MIN_W-1:0] cfg_wr_data,
  input  logic             in_tvalid,
  output logic             in_tready,
  // clock_us, woke_from_sleep, server_due, server_active, srv_left_us
  input  logic [135:0]     in_tdata,
  // kind
  input  logic [1:0]       in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // has_report_work, run_periodic, run_motion, elapsed_us, sleep_us,
  // clear_server_due
  output logic [135:0]     out_tdata
);

  logic    f_valid, f_ready;
  item_t   f_item;
  logic    q_valid, q_pop;
  item_t   q_item;
  result_t res;

  pwcs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .f_valid   (f_valid),
    .f_item    (f_item),
    .f_ready   (f_ready)
  );

  pwcs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_valid && f_ready),
    .push_item (f_item),
    .not_full  (f_ready),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  pwcs_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res         (res)
  );

  assign out_tdata = {6'b0, res};

  a_clear_imm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res.clear_server_due) |-> (res.sleep_us == IMMEDIATE_US[US_W-1:0]))
    else $error("overdue result without immediate wake");

  a_work_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (res.run_periodic || res.run_motion)) |-> res.has_report_work)
    else $error("capture chosen without report work");

  a_kind_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res.clear_server_due) |-> !res.has_report_work)
    else $error("sleep and wake results mixed");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import pwcs_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [MIN_W-1:0] cfg_wr_data;
  logic             in_tvalid;
  logic             in_tready;
  // clock_us, woke_from_sleep, server_due, server_active, srv_left_us
  logic [135:0]     in_tdata;
  // kind
  logic [1:0]       in_tuser;
  logic             out_tvalid;
  logic             out_tready;
  // has_report_work, run_periodic, run_motion, elapsed_us, sleep_us,
  // clear_server_due
  logic [135:0]     out_tdata;

  logic [MIN_W-1:0] period_min;
  longint           countdown;
  logic [63:0]      last_sleep_stamp;
  logic [63:0]      cycle_start_stamp;
  bit               periodic_ran;
  bit               motion_pending;

  result_t          sched_results_q[$];
  result_t          seen_res;
  result_t          want_res;
  int               mismatch_count;
  bit               tx_gaps;
  bit               rx_gaps;
  bit               rx_hold_start;
  int               rx_hold_left = 0;
  logic [63:0]      rtc;

  periodic_wake_countdown_scheduler u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic longint gap_sat(input logic [63:0] later, input logic [63:0] earlier);
    logic [63:0] d;
    d = later - earlier;
    return d[63] ? SMAX : $signed(d);
  endfunction

  function automatic longint sub_sat(input longint a, input longint b);
    if (b > 0 && a < SMIN + b) return SMIN;
    return a - b;
  endfunction

  function automatic longint add_sat(input longint a, input longint b);
    if (b > 0 && a > SMAX - b) return SMAX;
    return a + b;
  endfunction

  function automatic result_t schedule_step(input kind_t k, input logic [63:0] now,
                                            input bit woke, input bit due,
                                            input bit active, input longint left);
    result_t r;
    longint  slept;
    longint  work;
    longint  nxt;
    longint  lim;
    longint  per;
    bit      en;
    r   = '0;
    en  = period_min != 0;
    per = longint'(period_min) * longint'(US_PER_MINUTE);
    case (k)
      KIND_WAKE: begin
        slept = 0;
        periodic_ran = 1'b0;
        cycle_start_stamp = now;
        if (!woke || last_sleep_stamp == 0 || now < last_sleep_stamp) begin
          countdown = 0;
          last_sleep_stamp = now;
        end else begin
          slept = gap_sat(now, last_sleep_stamp);
          countdown = sub_sat(countdown, slept);
        end
        if (!en) countdown = SMAX;
        if (en && countdown <= TOLERANCE_US) periodic_ran = 1'b1;
        r.has_report_work = motion_pending || periodic_ran || due;
        r.run_periodic    = periodic_ran;
        r.run_motion      = motion_pending;
        r.elapsed_us      = slept[62:0];
        motion_pending = 1'b0;
      end
      KIND_SLEEP: begin
        work = 0;
        if (cycle_start_stamp > 0 && now >= cycle_start_stamp)
          work = gap_sat(now, cycle_start_stamp);
        last_sleep_stamp = now;
        countdown = sub_sat(countdown, work);
        r.elapsed_us = work[62:0];
        if (!periodic_ran && en && countdown <= 0) begin
          r.sleep_us         = IMMEDIATE_US[62:0];
          r.clear_server_due = 1'b1;
        end else begin
          if (en && periodic_ran) countdown = add_sat(countdown, per);
          if (en && !periodic_ran && (countdown <= 0 || countdown > per)) countdown = per;
          nxt = en ? countdown : -1;
          lim = en ? per : 0;
          if (active) begin
            if (left <= 0) nxt = IMMEDIATE_US;
            else if (nxt < 0 || left < nxt) nxt = left;
          end
          if (nxt >= 0) begin
            if (nxt == 0) begin
              nxt = en ? per : IMMEDIATE_US;
              if (en) countdown = per;
            end
            if (lim > 0 && nxt > lim) nxt = lim;
            r.sleep_us = nxt[62:0];
          end
        end
      end
      KIND_FORCE: countdown = 0;
      default: motion_pending = 1'b1;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] pick_left(input logic [63:0] per_us);
    logic [63:0] span;
    int          sel;
    span = (per_us != 0) ? 2 * per_us : 64'd200000000;
    sel  = $urandom_range(99);
    if (sel < 40) return rand64() % span;
    if (sel < 55) return -(rand64() % 64'd3000000);
    if (sel < 65) begin
      case ($urandom_range(3))
        0: return SMIN;
        1: return SMAX;
        2: return 64'd0;
        default: return '1;
      endcase
    end
    if (sel < 80) return rand64();
    return per_us + (rand64() % 64'd4000000) - 64'd2000000;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 100) $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_res = result_t'(out_tdata[129:0]);
      if (sched_results_q.size() == 0) begin
        report_mismatch($sformatf("result with no request pending: %0h", out_tdata));
      end else begin
        want_res = sched_results_q.pop_front();
        check_field("has_report_work", seen_res.has_report_work, want_res.has_report_work);
        check_field("run_periodic", seen_res.run_periodic, want_res.run_periodic);
        check_field("run_motion", seen_res.run_motion, want_res.run_motion);
        check_field("elapsed_us", seen_res.elapsed_us, want_res.elapsed_us);
        check_field("sleep_us", seen_res.sleep_us, want_res.sleep_us);
        check_field("clear_server_due", seen_res.clear_server_due, want_res.clear_server_due);
        check_field("tdata padding", 64'(out_tdata[135:130]), 64'd0);
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on demand
  always @(negedge clk) begin
    if (rx_hold_start) begin
      rx_hold_start = 1'b0;
      rx_hold_left  = 200;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !rx_gaps || ($urandom_range(99) >= 17);
    end
  end

  task automatic send_request(input kind_t k, input logic [63:0] now, input bit woke,
                              input bit due, input bit active, input logic [63:0] left);
    while (tx_gaps && $urandom_range(99) < 17) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= {5'b0, left, active, due, woke, now};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sched_results_q.push_back(schedule_step(k, now, woke, due, active, $signed(left)));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (sched_results_q.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_period(input logic [MIN_W-1:0] minutes);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= minutes;
    @(negedge clk);
    cfg_wr_en  <= 1'b0;
    period_min = minutes;
  endtask

  // mostly well-formed wake/sleep pairs on a running clock, some triggers and noise
  task automatic run_cycles(input int n_items);
    logic [63:0] per_us;
    logic [63:0] dur;
    logic [63:0] last_work;
    int          sel;
    int          sent;
    per_us    = 64'(period_min) * 64'(US_PER_MINUTE);
    last_work = 64'd0;
    sent      = 0;
    while (sent < n_items) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        send_request(kind_t'($urandom_range(3)), rand64(), 1'($urandom_range(1)),
                     1'($urandom_range(1)), 1'($urandom_range(1)), rand64());
        sent++;
      end else if (sel < 18) begin
        send_request($urandom_range(1) ? KIND_FORCE : KIND_MOTION, rtc,
                     1'($urandom_range(1)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), rand64());
        sent++;
      end else begin
        sel = $urandom_range(99);
        if (sel < 5)
          dur = rand64() >> $urandom_range(63);
        else if (per_us == 0 || sel < 15 || last_work >= per_us)
          dur = 64'($urandom_range(120000000));
        else
          dur = per_us - last_work - 64'd4000000 + 64'($urandom_range(8000000));
        rtc += dur;
        send_request(KIND_WAKE, rtc, $urandom_range(99) < 92, 1'($urandom_range(1)),
                     1'($urandom_range(1)), rand64());
        sel = $urandom_range(99);
        if (sel < 85)
          last_work = 64'($urandom_range(5000000));
        else if (sel < 95)
          last_work = per_us + 64'($urandom_range(4000000));
        else
          last_work = rand64() >> $urandom_range(63);
        rtc += last_work;
        send_request(KIND_SLEEP, rtc, 1'($urandom_range(1)), 1'($urandom_range(1)),
                     $urandom_range(99) < 60, pick_left(per_us));
        sent += 2;
      end
    end
  endtask

  task automatic test_disabled_period();
    send_request(KIND_WAKE, 64'd0, 1'b0, 1'b1, 1'b0, 64'd0);
    send_request(KIND_SLEEP, 64'd5000000, 1'b0, 1'b0, 1'b0, 64'd0);
    send_request(KIND_SLEEP, '1, 1'b1, 1'b1, 1'b1, SMAX);
    send_request(KIND_WAKE, '1, 1'b1, 1'b0, 1'b0, 64'd0);
    send_request(KIND_SLEEP, '1, 1'b0, 1'b0, 1'b1, 64'd0);
    send_request(KIND_SLEEP, '1, 1'b0, 1'b0, 1'b1, SMIN);
    send_request(KIND_MOTION, rand64(), 1'b1, 1'b1, 1'b1, rand64());
    send_request(KIND_FORCE, rand64(), 1'b1, 1'b1, 1'b1, rand64());
    // leaves the countdown at its top value before the period is enabled
    send_request(KIND_WAKE, 64'd7, 1'b1, 1'b0, 1'b0, 64'd0);
  endtask

  task automatic test_wake_sleep_cases();
    logic [63:0] t;
    write_period(11'd1);
    send_request(KIND_SLEEP, 64'd20, 1'b0, 1'b0, 1'b0, 64'd0);
    t = 64'd1000;
    send_request(KIND_MOTION, rand64(), 1'b1, 1'b1, 1'b1, rand64());
    send_request(KIND_WAKE, t, 1'b0, 1'b0, 1'b0, 64'd0);
    t += 64'd3000000;
    send_request(KIND_SLEEP, t, 1'b0, 1'b0, 1'b1, SMIN);
    t += 64'd50000000;
    send_request(KIND_WAKE, t, 1'b1, 1'b0, 1'b0, 64'd0);
    t += 64'd10000000;
    send_request(KIND_SLEEP, t, 1'b0, 1'b0, 1'b1, 64'd5);
    t += 64'd1000000;
    send_request(KIND_WAKE, t, 1'b1, 1'b1, 1'b0, 64'd0);
    t += 64'd500;
    send_request(KIND_SLEEP, t, 1'b0, 1'b0, 1'b1, 64'd1);
    send_request(KIND_FORCE, rand64(), 1'b0, 1'b0, 1'b0, 64'd0);
    send_request(KIND_WAKE, t - 64'd10, 1'b1, 1'b0, 1'b0, 64'd0);
    send_request(KIND_SLEEP, t - 64'd20, 1'b0, 1'b0, 1'b0, 64'd0);
    send_request(KIND_WAKE, '1, 1'b1, 1'b0, 1'b0, 64'd0);
    send_request(KIND_SLEEP, '1, 1'b0, 1'b0, 1'b1, SMAX);
    send_request(KIND_WAKE, 64'd5, 1'b1, 1'b0, 1'b0, 64'd0);
    send_request(KIND_SLEEP, {1'b1, 63'd10}, 1'b0, 1'b0, 1'b0, 64'd0);
    send_request(KIND_WAKE, '1, 1'b1, 1'b0, 1'b0, 64'd0);
    send_request(KIND_SLEEP, '1, 1'b0, 1'b0, 1'b1, 64'd0);
  endtask

  task automatic test_period_sweep();
    logic [MIN_W-1:0] minutes;
    int               i;
    for (i = 0; i < 7; i++) begin
      if (i == 0) minutes = '0;
      else if (i == 1) minutes = 11'd1440;
      else if (i == 2) minutes = 11'd1;
      else minutes = MIN_W'($urandom_range(1440, 2));
      write_period(minutes);
      run_cycles(150);
    end
  endtask

  task automatic test_no_idle_stretch();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    run_cycles(150);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  // receiver holds off while requests keep coming, then the sender drains
  task automatic test_backpressure();
    wait_idle();
    rx_hold_start = 1'b1;
    tx_gaps = 1'b0;
    run_cycles(40);
    tx_gaps = 1'b1;
    wait_idle();
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    out_tready     = 1'b0;
    period_min     = '0;
    countdown      = 0;
    last_sleep_stamp  = '0;
    cycle_start_stamp = '0;
    periodic_ran   = 1'b0;
    motion_pending = 1'b0;
    mismatch_count = 0;
    tx_gaps        = 1'b1;
    rx_gaps        = 1'b1;
    rx_hold_start  = 1'b0;
    rtc            = 64'($urandom_range(1000000, 1));
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_disabled_period();
    test_wake_sleep_cases();
    test_period_sweep();
    test_no_idle_stretch();
    test_backpressure();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- periodic_wake_countdown_scheduler.f -----
design/pwcs_pkg.sv
design/pwcs_front.sv
design/pwcs_queue.sv
design/pwcs_back.sv
design/periodic_wake_countdown_scheduler.sv
tb/tb.sv
